// ===== hw/rtl/ctsc_pkg.sv =====
package ctsc_pkg;

	localparam int unsigned CfgWidth = 16;
	localparam int unsigned TimerWidth = 16;
	localparam int unsigned AgeWidth = 32;
	localparam int unsigned InDataWidth = 48;
	localparam int unsigned OutDataWidth = 16;

	localparam logic [CfgWidth-1:0] AckWaitReset = 16'd8000;
	localparam logic [CfgWidth-1:0] ResultHoldReset = 16'd4000;
	localparam logic [CfgWidth-1:0] DiagRefreshReset = 16'd500;
	localparam logic [AgeWidth-1:0] AgeNever = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REG_ACK_WAIT     = 2'd0,
		REG_RESULT_HOLD  = 2'd1,
		REG_DIAG_REFRESH = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_UP     = 3'd1,
		CMD_DOWN   = 3'd2,
		CMD_ACCEPT = 3'd3,
		CMD_CANCEL = 3'd4,
		CMD_ENTER  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_REDRAW    = 3'd1,
		ACT_COMMIT    = 3'd2,
		ACT_SYNC_OK   = 3'd3,
		ACT_SYNC_FAIL = 3'd4,
		ACT_STOPPED   = 3'd5,
		ACT_DIAG      = 3'd6,
		ACT_EXIT      = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		PH_EDIT   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_RESULT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CfgWidth-1:0] ack_wait_ms;
		logic [CfgWidth-1:0] result_hold_ms;
		logic [CfgWidth-1:0] diag_refresh_ms;
	} cfg_t;

	typedef struct packed {
		logic [AgeWidth-1:0] sync_age_ms;
		logic                clock_running;
		logic [5:0]          start_minute;
		logic [4:0]          start_hour;
		cmd_t                command;
	} item_t;

	typedef struct packed {
		logic       heartbeat;
		phase_t     phase_now;
		logic [1:0] cursor_pos;
		logic [5:0] edit_minute;
		logic [4:0] edit_hour;
		action_t    action;
	} result_t;

endpackage

// ===== hw/rtl/ctsc_core.sv =====
module ctsc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ctsc_pkg::item_t  item,
	input  ctsc_pkg::cfg_t   cfg,
	output ctsc_pkg::result_t res
);

	logic [1:0]                            hour_tens_q, hour_tens_d;
	logic [3:0]                            hour_units_q, hour_units_d;
	logic [2:0]                            minute_tens_q, minute_tens_d;
	logic [3:0]                            minute_units_q, minute_units_d;
	logic [1:0]                            cursor_q, cursor_d;
	ctsc_pkg::phase_t                      phase_q, phase_d;
	logic [ctsc_pkg::TimerWidth-1:0]       phase_elapsed_q, phase_elapsed_d;
	logic [ctsc_pkg::TimerWidth-1:0]       diag_elapsed_q, diag_elapsed_d;
	logic                                  stopped_q, stopped_d;
	logic                                  heartbeat_q, heartbeat_d;
	ctsc_pkg::action_t                     action;

	logic [ctsc_pkg::TimerWidth-1:0] pe_inc, de_inc;
	logic [3:0] dig, modulus, dig_up, dig_down, dig_new;
	logic [4:0] ent_hour, hour_rest;
	logic [5:0] ent_minute;
	logic [1:0] ent_ht;
	logic [2:0] ent_mt;
	logic [3:0] ent_hu, ent_mu;
	logic [5:0] min_rest;

	assign pe_inc = (&phase_elapsed_q) ? phase_elapsed_q : phase_elapsed_q + 1'b1;
	assign de_inc = (&diag_elapsed_q) ? diag_elapsed_q : diag_elapsed_q + 1'b1;

	always_comb begin
		case (cursor_q)
			2'd0: begin
				dig = {2'b00, hour_tens_q};
				modulus = 4'd3;
			end
			2'd1: begin
				dig = hour_units_q;
				modulus = (hour_tens_q == 2'd2) ? 4'd4 : 4'd10;
			end
			2'd2: begin
				dig = {1'b0, minute_tens_q};
				modulus = 4'd6;
			end
			default: begin
				dig = minute_units_q;
				modulus = 4'd10;
			end
		endcase
	end

	assign dig_up = (dig == modulus - 4'd1) ? 4'd0 : dig + 4'd1;
	assign dig_down = (dig == 4'd0) ? modulus - 4'd1 : dig - 4'd1;
	assign dig_new = (item.command == ctsc_pkg::CMD_UP) ? dig_up : dig_down;

	// split the loaded time into digits
	always_comb begin
		ent_hour = 5'd0;
		ent_minute = 6'd0;
		if (item.clock_running) begin
			ent_hour = (item.start_hour > 5'd23) ? 5'd23 : item.start_hour;
			ent_minute = (item.start_minute > 6'd59) ? 6'd59 : item.start_minute;
		end
		if (ent_hour >= 5'd20) begin
			ent_ht = 2'd2;
			hour_rest = ent_hour - 5'd20;
		end else if (ent_hour >= 5'd10) begin
			ent_ht = 2'd1;
			hour_rest = ent_hour - 5'd10;
		end else begin
			ent_ht = 2'd0;
			hour_rest = ent_hour;
		end
		ent_hu = hour_rest[3:0];
		if (ent_minute >= 6'd50) begin
			ent_mt = 3'd5;
			min_rest = ent_minute - 6'd50;
		end else if (ent_minute >= 6'd40) begin
			ent_mt = 3'd4;
			min_rest = ent_minute - 6'd40;
		end else if (ent_minute >= 6'd30) begin
			ent_mt = 3'd3;
			min_rest = ent_minute - 6'd30;
		end else if (ent_minute >= 6'd20) begin
			ent_mt = 3'd2;
			min_rest = ent_minute - 6'd20;
		end else if (ent_minute >= 6'd10) begin
			ent_mt = 3'd1;
			min_rest = ent_minute - 6'd10;
		end else begin
			ent_mt = 3'd0;
			min_rest = ent_minute;
		end
		ent_mu = min_rest[3:0];
	end

	always_comb begin
		hour_tens_d = hour_tens_q;
		hour_units_d = hour_units_q;
		minute_tens_d = minute_tens_q;
		minute_units_d = minute_units_q;
		cursor_d = cursor_q;
		phase_d = phase_q;
		phase_elapsed_d = phase_elapsed_q;
		diag_elapsed_d = diag_elapsed_q;
		stopped_d = stopped_q;
		heartbeat_d = heartbeat_q;
		action = ctsc_pkg::ACT_NONE;
		case (item.command)
			ctsc_pkg::CMD_ENTER: begin
				hour_tens_d = ent_ht;
				hour_units_d = ent_hu;
				minute_tens_d = ent_mt;
				minute_units_d = ent_mu;
				cursor_d = 2'd0;
				phase_d = ctsc_pkg::PH_EDIT;
				stopped_d = 1'b0;
				action = ctsc_pkg::ACT_REDRAW;
			end
			ctsc_pkg::CMD_TICK, ctsc_pkg::CMD_UP, ctsc_pkg::CMD_DOWN,
			ctsc_pkg::CMD_ACCEPT, ctsc_pkg::CMD_CANCEL: begin
				case (phase_q)
					ctsc_pkg::PH_WAIT: begin
						if (item.command == ctsc_pkg::CMD_TICK) begin
							phase_elapsed_d = pe_inc;
							if (item.sync_age_ms != ctsc_pkg::AgeNever &&
								item.sync_age_ms <= {{(ctsc_pkg::AgeWidth -
								ctsc_pkg::TimerWidth){1'b0}}, pe_inc}) begin
								phase_d = ctsc_pkg::PH_RESULT;
								phase_elapsed_d = '0;
								action = ctsc_pkg::ACT_SYNC_OK;
							end else if (pe_inc >= cfg.ack_wait_ms) begin
								phase_d = ctsc_pkg::PH_RESULT;
								phase_elapsed_d = '0;
								action = ctsc_pkg::ACT_SYNC_FAIL;
							end
						end
					end
					ctsc_pkg::PH_RESULT: begin
						if (item.command == ctsc_pkg::CMD_TICK) begin
							phase_elapsed_d = pe_inc;
							diag_elapsed_d = de_inc;
							if (stopped_q) begin
								if (de_inc >= cfg.diag_refresh_ms) begin
									diag_elapsed_d = '0;
									heartbeat_d = ~heartbeat_q;
									action = ctsc_pkg::ACT_DIAG;
								end
							end else if (pe_inc >= cfg.result_hold_ms) begin
								phase_d = ctsc_pkg::PH_EDIT;
								action = ctsc_pkg::ACT_EXIT;
							end
						end else begin
							phase_d = ctsc_pkg::PH_EDIT;
							action = ctsc_pkg::ACT_EXIT;
						end
					end
					default: begin
						case (item.command)
							ctsc_pkg::CMD_UP, ctsc_pkg::CMD_DOWN: begin
								case (cursor_q)
									2'd0: hour_tens_d = dig_new[1:0];
									2'd1: hour_units_d = dig_new;
									2'd2: minute_tens_d = dig_new[2:0];
									default: minute_units_d = dig_new;
								endcase
								if (hour_tens_d == 2'd2 && hour_units_d > 4'd3)
									hour_units_d = 4'd3;
								action = ctsc_pkg::ACT_REDRAW;
							end
							ctsc_pkg::CMD_ACCEPT: begin
								if (cursor_q != 2'd3) begin
									cursor_d = cursor_q + 2'd1;
									action = ctsc_pkg::ACT_REDRAW;
								end else if (!item.clock_running) begin
									stopped_d = 1'b1;
									phase_d = ctsc_pkg::PH_RESULT;
									phase_elapsed_d = '0;
									diag_elapsed_d = '0;
									heartbeat_d = 1'b0;
									action = ctsc_pkg::ACT_STOPPED;
								end else begin
									stopped_d = 1'b0;
									phase_d = ctsc_pkg::PH_WAIT;
									phase_elapsed_d = '0;
									action = ctsc_pkg::ACT_COMMIT;
								end
							end
							ctsc_pkg::CMD_CANCEL: action = ctsc_pkg::ACT_EXIT;
							default: action = ctsc_pkg::ACT_NONE;
						endcase
					end
				endcase
			end
			default: action = ctsc_pkg::ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_tens_q <= '0;
			hour_units_q <= '0;
			minute_tens_q <= '0;
			minute_units_q <= '0;
			cursor_q <= '0;
			phase_q <= ctsc_pkg::PH_EDIT;
			phase_elapsed_q <= '0;
			diag_elapsed_q <= '0;
			stopped_q <= 1'b0;
			heartbeat_q <= 1'b0;
		end else if (step) begin
			hour_tens_q <= hour_tens_d;
			hour_units_q <= hour_units_d;
			minute_tens_q <= minute_tens_d;
			minute_units_q <= minute_units_d;
			cursor_q <= cursor_d;
			phase_q <= phase_d;
			phase_elapsed_q <= phase_elapsed_d;
			diag_elapsed_q <= diag_elapsed_d;
			stopped_q <= stopped_d;
			heartbeat_q <= heartbeat_d;
		end
	end

	always_comb begin
		res.action = action;
		res.edit_hour = {hour_tens_d, 3'b000} + {2'b00, hour_tens_d, 1'b0}
			+ {1'b0, hour_units_d};
		res.edit_minute = {minute_tens_d, 3'b000} + {2'b00, minute_tens_d, 1'b0}
			+ {2'b00, minute_units_d};
		res.cursor_pos = cursor_d;
		res.phase_now = phase_d;
		res.heartbeat = heartbeat_d;
	end

endmodule

// ===== hw/rtl/clock_time_set_controller_unit.sv =====
// Time-set digit editor for an HH:MM clock.
// Input channel s_*: one item per handshake. s_tuser carries the command
// (tick of 1 ms, up, down, accept, cancel, enter); s_tdata carries the
// start time, the clock-running flag and the sync age.
// Output channel m_*: exactly one result item per input item, in order.
// m_tuser carries the action code; m_tdata the edited hour and minute,
// cursor, phase and heartbeat as they stand after the item.
// Configuration: write cfg_data into register cfg_index while cfg_we is
// high (0 ack wait, 1 result hold, 2 diagnostic refresh, all in ms).
// Path: an item goes into the input register, then its result into the result
// register; a stall on m_* can hold it between the two. Throughput: one item
// per cycle unless m_tready stalls the output, set by the combinational state update.
// Reset: digits, cursor, timers and flags clear, phase returns to editing,
// registers take their defaults (8000, 4000, 500 ms); both channels empty.
// Stall: while m_tready is low the result holds, one more item is taken
// into the input register, then s_tready drops until the result leaves.
module clock_time_set_controller_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [43:12] sync_age_ms, [11] clock_running, [10:5] start_minute,
	// [4:0] start_hour, [47:44] zero
	input  logic [ctsc_pkg::InDataWidth-1:0]      s_tdata,
	// [2:0] command
	input  logic [2:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [15] heartbeat, [14:13] phase_now, [12:11] cursor_pos,
	// [10:5] edit_minute, [4:0] edit_hour
	output logic [ctsc_pkg::OutDataWidth-1:0]     m_tdata,
	// [2:0] action
	output logic [2:0]                            m_tuser,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [ctsc_pkg::CfgWidth-1:0]         cfg_data
);

	logic              item_v_s1;
	ctsc_pkg::item_t   item_s1;
	logic              out_v_q;
	ctsc_pkg::result_t res_q;
	ctsc_pkg::result_t res;
	ctsc_pkg::cfg_t    cfg_q;
	logic              advance;
	logic              take;

	assign advance = item_v_s1 && (!out_v_q || m_tready);
	assign s_tready = !item_v_s1 || advance;
	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_wait_ms <= ctsc_pkg::AckWaitReset;
			cfg_q.result_hold_ms <= ctsc_pkg::ResultHoldReset;
			cfg_q.diag_refresh_ms <= ctsc_pkg::DiagRefreshReset;
		end else if (cfg_we) begin
			case (cfg_index)
				ctsc_pkg::REG_ACK_WAIT: cfg_q.ack_wait_ms <= cfg_data;
				ctsc_pkg::REG_RESULT_HOLD: cfg_q.result_hold_ms <= cfg_data;
				ctsc_pkg::REG_DIAG_REFRESH: cfg_q.diag_refresh_ms <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take)
				item_v_s1 <= 1'b1;
			else if (advance)
				item_v_s1 <= 1'b0;
			if (advance)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command <= ctsc_pkg::cmd_t'(s_tuser);
			item_s1.start_hour <= s_tdata[4:0];
			item_s1.start_minute <= s_tdata[10:5];
			item_s1.clock_running <= s_tdata[11];
			item_s1.sync_age_ms <= s_tdata[43:12];
		end
		if (advance)
			res_q <= res;
	end

	ctsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_tvalid = out_v_q;
	assign m_tuser = res_q.action;
	assign m_tdata = {res_q.heartbeat, res_q.phase_now, res_q.cursor_pos,
		res_q.edit_minute, res_q.edit_hour};

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> item_v_s1 && out_v_q && !m_tready)
		else $error("input held off without a full pipeline");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] <= 5'd23 && m_tdata[10:5] <= 6'd59)
		else $error("edited time out of range");

	a_commit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ctsc_pkg::ACT_COMMIT |->
		m_tdata[14:13] == ctsc_pkg::PH_WAIT && m_tdata[12:11] == 2'd3)
		else $error("commit without entering the wait phase");

	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ctsc_pkg::ACT_SYNC_OK ||
		m_tuser == ctsc_pkg::ACT_SYNC_FAIL || m_tuser == ctsc_pkg::ACT_STOPPED ||
		m_tuser == ctsc_pkg::ACT_DIAG) |-> m_tdata[14:13] == ctsc_pkg::PH_RESULT)
		else $error("result action outside the result phase");
`endif

endmodule

// ===== bench/clock_time_set_controller_unit_tb.sv =====
`timescale 1ns / 1ps
module clock_time_set_controller_unit_tb;
	import ctsc_pkg::*;

	localparam int unsigned WatchLimit = 2000;
	localparam int unsigned DrainCycles = 4;
	localparam int unsigned ItemsPerPhase = 300;
	localparam logic [1:0] RegSpare = 2'd3;
	localparam logic [2:0] CmdSpareLow = 3'd6;
	localparam logic [2:0] CmdSpareHigh = 3'd7;

	class time_editor_model;
		logic [CfgWidth-1:0] ack_wait = AckWaitReset;
		logic [CfgWidth-1:0] result_hold = ResultHoldReset;
		logic [CfgWidth-1:0] diag_refresh = DiagRefreshReset;
		logic [1:0] hour_tens = '0;
		logic [3:0] hour_units = '0;
		logic [2:0] minute_tens = '0;
		logic [3:0] minute_units = '0;
		logic [1:0] cursor = '0;
		phase_t phase = PH_EDIT;
		logic [TimerWidth-1:0] phase_elapsed = '0;
		logic [TimerWidth-1:0] diag_elapsed = '0;
		logic stopped = 1'b0;
		logic heartbeat = 1'b0;
		result_t expected_results[$];
		int errors = 0;
		int checked = 0;
		int taken = 0;
		int effective_items = 0;
		int action_seen[8];

		function void set_register(reg_index_t idx, logic [CfgWidth-1:0] value);
			case (idx)
				REG_ACK_WAIT: ack_wait = value;
				REG_RESULT_HOLD: result_hold = value;
				REG_DIAG_REFRESH: diag_refresh = value;
				default: ;
			endcase
		endfunction

		function logic [TimerWidth-1:0] count_up(logic [TimerWidth-1:0] t);
			return (t == '1) ? t : t + 1'b1;
		endfunction

		function logic [3:0] roll(logic [3:0] d, int unsigned modv, bit inc);
			int unsigned v;
			v = inc ? (d + 1) % modv : (d + modv - 1) % modv;
			return v[3:0];
		endfunction

		function void take_item(item_t it);
			action_t act;
			logic [4:0] h;
			logic [5:0] m;
			result_t r;
			bit busy;
			bit inc;
			act = ACT_NONE;
			taken++;
			busy = (phase != PH_EDIT);
			if (it.command == CMD_ENTER) begin
				h = '0;
				m = '0;
				if (it.clock_running) begin
					h = (it.start_hour > 5'd23) ? 5'd23 : it.start_hour;
					m = (it.start_minute > 6'd59) ? 6'd59 : it.start_minute;
				end
				hour_tens = 2'(h / 10);
				hour_units = 4'(h % 10);
				minute_tens = 3'(m / 10);
				minute_units = 4'(m % 10);
				cursor = '0;
				phase = PH_EDIT;
				stopped = 1'b0;
				act = ACT_REDRAW;
			end else if (it.command > CMD_ENTER) begin
				act = ACT_NONE;
			end else if (phase == PH_WAIT) begin
				if (it.command == CMD_TICK) begin
					phase_elapsed = count_up(phase_elapsed);
					if (it.sync_age_ms != AgeNever && it.sync_age_ms <=
						{{(AgeWidth - TimerWidth){1'b0}}, phase_elapsed}) begin
						phase = PH_RESULT;
						phase_elapsed = '0;
						act = ACT_SYNC_OK;
					end else if (phase_elapsed >= ack_wait) begin
						phase = PH_RESULT;
						phase_elapsed = '0;
						act = ACT_SYNC_FAIL;
					end
				end
			end else if (phase == PH_RESULT) begin
				if (it.command == CMD_TICK) begin
					phase_elapsed = count_up(phase_elapsed);
					diag_elapsed = count_up(diag_elapsed);
					if (stopped) begin
						if (diag_elapsed >= diag_refresh) begin
							diag_elapsed = '0;
							heartbeat = ~heartbeat;
							act = ACT_DIAG;
						end
					end else if (phase_elapsed >= result_hold) begin
						phase = PH_EDIT;
						act = ACT_EXIT;
					end
				end else begin
					phase = PH_EDIT;
					act = ACT_EXIT;
				end
			end else begin
				case (it.command)
					CMD_UP, CMD_DOWN: begin
						inc = (it.command == CMD_UP);
						case (cursor)
							2'd0: hour_tens = 2'(roll({2'b00, hour_tens}, 3, inc));
							2'd1: hour_units = roll(hour_units, (hour_tens == 2'd2) ? 4 : 10, inc);
							2'd2: minute_tens = 3'(roll({1'b0, minute_tens}, 6, inc));
							default: minute_units = roll(minute_units, 10, inc);
						endcase
						if (hour_tens == 2'd2 && hour_units > 4'd3)
							hour_units = 4'd3;
						act = ACT_REDRAW;
					end
					CMD_ACCEPT: begin
						if (cursor < 2'd3) begin
							cursor = cursor + 1'b1;
							act = ACT_REDRAW;
						end else if (!it.clock_running) begin
							stopped = 1'b1;
							phase = PH_RESULT;
							phase_elapsed = '0;
							diag_elapsed = '0;
							heartbeat = 1'b0;
							act = ACT_STOPPED;
						end else begin
							stopped = 1'b0;
							phase = PH_WAIT;
							phase_elapsed = '0;
							act = ACT_COMMIT;
						end
					end
					CMD_CANCEL: act = ACT_EXIT;
					default: act = ACT_NONE;
				endcase
			end
			if (act != ACT_NONE || (it.command == CMD_TICK && busy))
				effective_items++;
			r.action = act;
			r.edit_hour = hour_tens * 5'd10 + hour_units;
			r.edit_minute = minute_tens * 6'd10 + minute_units;
			r.cursor_pos = cursor;
			r.phase_now = phase;
			r.heartbeat = heartbeat;
			expected_results.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report("unexpected result, action", got.action, 0);
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (!$isunknown(got.action))
				action_seen[got.action]++;
			if (got.action !== want.action)
				report("action", got.action, want.action);
			if (got.edit_hour !== want.edit_hour)
				report("edit_hour", got.edit_hour, want.edit_hour);
			if (got.edit_minute !== want.edit_minute)
				report("edit_minute", got.edit_minute, want.edit_minute);
			if (got.cursor_pos !== want.cursor_pos)
				report("cursor_pos", got.cursor_pos, want.cursor_pos);
			if (got.phase_now !== want.phase_now)
				report("phase_now", got.phase_now, want.phase_now);
			if (got.heartbeat !== want.heartbeat)
				report("heartbeat", got.heartbeat, want.heartbeat);
		endtask

		task finish_check();
			if (expected_results.size() != 0)
				report("results never delivered", expected_results.size(), 0);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataWidth-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutDataWidth-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CfgWidth-1:0] cfg_data = '0;

	int send_idle_pct = 21;
	int recv_idle_pct = 68;
	int quiet_cycles = 0;
	time_editor_model model = new();

	clock_time_set_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			model.take_item(item_t'({s_tdata[43:0], s_tuser}));
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_result(result_t'({m_tdata, m_tuser}));
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchLimit) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_item(cmd_t c, logic run, logic [4:0] h, logic [5:0] m,
			logic [31:0] age);
		item_t it;
		it.command = c;
		it.clock_running = run;
		it.start_hour = h;
		it.start_minute = m;
		it.sync_age_ms = age;
		return it;
	endfunction

	function automatic item_t random_item(cmd_t c, logic [31:0] age);
		logic [4:0] h;
		logic [5:0] m;
		h = 5'($urandom_range(0, 31));
		m = 6'($urandom_range(0, 63));
		return make_item(c, $urandom_range(0, 3) != 0, h, m, age);
	endfunction

	function automatic cmd_t any_command();
		logic [2:0] raw;
		raw = 3'($urandom_range(0, 7));
		return cmd_t'(raw);
	endfunction

	function automatic logic [31:0] pick_age(int kind, int cap);
		case (kind)
			0: return AgeNever;
			1: return $urandom_range(0, cap + 3);
			2: return $urandom;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	task automatic send_item(input item_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, it.sync_age_ms, it.clock_running, it.start_minute, it.start_hour};
		s_tuser <= it.command;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		while (model.expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_settings(input logic [CfgWidth-1:0] ack, hold, diag);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACK_WAIT;
		cfg_data <= ack;
		@(posedge clk);
		model.set_register(REG_ACK_WAIT, ack);
		cfg_index <= REG_RESULT_HOLD;
		cfg_data <= hold;
		@(posedge clk);
		model.set_register(REG_RESULT_HOLD, hold);
		cfg_index <= REG_DIAG_REFRESH;
		cfg_data <= diag;
		@(posedge clk);
		model.set_register(REG_DIAG_REFRESH, diag);
		cfg_index <= RegSpare;
		cfg_data <= CfgWidth'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// enter, edit the four digits, accept each (commit or stop), then tick through the wait and result
	task automatic run_session(input int cap);
		int kind;
		int n;
		kind = $urandom_range(0, 3);
		send_item(random_item(CMD_ENTER, $urandom));
		for (int d = 0; d < 4; d++) begin
			n = $urandom_range(0, 3);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_item(random_item(any_command(), $urandom));
				else
					send_item(random_item($urandom_range(0, 1) ? CMD_UP : CMD_DOWN, $urandom));
			end
			send_item(make_item(CMD_ACCEPT, $urandom_range(0, 4) != 0,
				5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), $urandom));
		end
		n = $urandom_range(1, 2 * cap + 6);
		repeat (n) send_item(random_item(CMD_TICK, pick_age(kind, cap)));
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 3))
				0: send_item(random_item(CMD_UP, $urandom));
				1: send_item(random_item(CMD_DOWN, $urandom));
				2: send_item(random_item(CMD_ACCEPT, $urandom));
				default: send_item(random_item(CMD_CANCEL, $urandom));
			endcase
		end
	endtask

	initial begin
		int goal;
		int cap;
		logic [CfgWidth-1:0] ack;
		logic [CfgWidth-1:0] hold;
		logic [CfgWidth-1:0] diag;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(random_item(CMD_TICK, $urandom));
		send_item(random_item(cmd_t'(CmdSpareLow), $urandom));
		send_item(random_item(cmd_t'(CmdSpareHigh), $urandom));
		send_item(make_item(CMD_ENTER, 1'b1, 5'd31, 6'd63, '0));
		send_item(make_item(CMD_ENTER, 1'b0, 5'd12, 6'd34, '1));
		send_item(make_item(CMD_ENTER, 1'b1, 5'd19, 6'd45, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_DOWN, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_ACCEPT, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_DOWN, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_ACCEPT, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_ACCEPT, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_DOWN, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_CANCEL, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_ACCEPT, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_UP, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_TICK, 1'b1, '0, '0, AgeNever));
		send_item(make_item(CMD_TICK, 1'b1, '0, '0, 32'd2));
		send_item(make_item(CMD_CANCEL, 1'b1, '0, '0, '0));
		send_item(make_item(CMD_ACCEPT, 1'b0, '0, '0, '0));
		send_item(make_item(CMD_TICK, 1'b0, '0, '0, '0));
		send_item(make_item(CMD_DOWN, 1'b0, '0, '0, '0));
		s_tvalid <= 1'b0;

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: write_settings(16'd1, 16'd1, 16'd1);
				1: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: write_settings(16'd0, 16'd0, 16'd0);
				default: begin
					ack = CfgWidth'($urandom_range(1, 40));
					hold = CfgWidth'($urandom_range(1, 40));
					diag = CfgWidth'($urandom_range(1, 40));
					write_settings(ack, hold, diag);
				end
			endcase
			if (p < 2) begin
				send_idle_pct = 21;
				recv_idle_pct = 68;
			end else if (p < 4) begin
				send_idle_pct = 68;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			cap = (model.ack_wait > 60) ? 60 : int'(model.ack_wait);
			goal = model.taken + ItemsPerPhase;
			while (model.taken < goal) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 8)) send_item(random_item(any_command(), $urandom));
				else
					run_session(cap);
			end
			s_tvalid <= 1'b0;
		end

		settle();
		model.finish_check();
		$display("Checked %0d results from %0d items (%0d active) over six timer settings.",
			model.checked, model.taken, model.effective_items);
		$display("Commits %0d, sync ok %0d, sync fail %0d, stopped %0d, refreshes %0d, exits %0d.",
			model.action_seen[ACT_COMMIT], model.action_seen[ACT_SYNC_OK],
			model.action_seen[ACT_SYNC_FAIL], model.action_seen[ACT_STOPPED],
			model.action_seen[ACT_DIAG], model.action_seen[ACT_EXIT]);
		if (model.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ctsc_pkg.sv
hw/rtl/ctsc_core.sv
hw/rtl/clock_time_set_controller_unit.sv
bench/clock_time_set_controller_unit_tb.sv
